>>> hdl/deos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dataset extrema and order scan package
// Shared types and constants for the row and result channels.
// ----------------------------------------------------------------------------
package deos_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned COLS_W   = 3;
    localparam logic [COLS_W-1:0] COLS_RESET = 3'd2;

    typedef enum logic [1:0] {
        ORD_NONE = 2'd0,
        ORD_ASC  = 2'd1,
        ORD_DESC = 2'd2
    } t_order;

    typedef struct packed {
        logic                       first_row;
        logic                       last_row;
        logic signed [SAMPLE_W-1:0] col0;
        logic signed [SAMPLE_W-1:0] col1;
        logic signed [SAMPLE_W-1:0] col2;
        logic signed [SAMPLE_W-1:0] col3;
    } t_row;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] min0;
        logic signed [SAMPLE_W-1:0] max0;
        logic signed [SAMPLE_W-1:0] min1;
        logic signed [SAMPLE_W-1:0] max1;
        logic signed [SAMPLE_W-1:0] min2;
        logic signed [SAMPLE_W-1:0] max2;
        logic signed [SAMPLE_W-1:0] min3;
        logic signed [SAMPLE_W-1:0] max3;
        logic [1:0]                 ordering;
        logic                       equally_spaced;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/deos_row_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Row channel
// Valid/ready channel that carries one dataset row per transfer.
// ----------------------------------------------------------------------------
interface deos_row_if
    import deos_pkg::*;
;
    logic valid;
    logic ready;
    t_row data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/deos_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one dataset summary per transfer.
// ----------------------------------------------------------------------------
interface deos_res_if
    import deos_pkg::*;
;
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/dataset_extrema_order_scan.sv
`default_nettype none
// A last row passes the input register, then the output register, which holds its result.
// Throughput: one row per cycle unless the result stalls; state is updated once per row.
// A stalled result holds the row in the input register until the result is taken.
// Reset is synchronous and active low; it clears the valid flags, the row count and
// sets the column count to two, so the next row always opens a new dataset.
// ----------------------------------------------------------------------------
// Dataset extrema and order scan
// Tracks per-column running minimum and maximum, abscissa ordering and
// equal spacing over a dataset, and emits a summary after the last row.
// ----------------------------------------------------------------------------
module dataset_extrema_order_scan
    import deos_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [COLS_W-1:0]    i_cfg_wdata,
    deos_row_if.sink            i_row,
    deos_res_if.source          o_res
);

    localparam int unsigned NUM_EXT = 2 * MAX_COLUMNS;
    localparam logic [COLS_W-1:0] MAX_COLS = COLS_W'(MAX_COLUMNS);

    logic [COLS_W-1:0]          r_cols;
    logic                       r_in_valid;
    t_row                       r_in_data;
    logic                       r_out_valid;
    t_result                    r_out_data;

    logic signed [SAMPLE_W-1:0] r_ext [NUM_EXT];
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W:0]   r_step;
    t_order                     r_order;
    logic                       r_spacing;
    logic [1:0]                 r_rows;

    logic signed [SAMPLE_W-1:0] n_ext [NUM_EXT];
    logic signed [SAMPLE_W:0]   n_step;
    t_order                     n_order;
    logic                       n_spacing;
    logic [1:0]                 n_rows;
    t_result                    n_result;

    logic                       advance;
    logic                       proc;
    logic                       start;
    logic signed [SAMPLE_W-1:0] x [4];
    logic signed [SAMPLE_W:0]   diff;
    logic                       down;
    logic                       up;
    logic [COLS_W-1:0]          used;
    logic signed [SAMPLE_W-1:0] shown [8];

    assign advance     = !r_out_valid || o_res.ready;
    assign proc        = r_in_valid && advance;
    assign i_row.ready = !r_in_valid || advance;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    assign x[0] = r_in_data.col0;
    assign x[1] = r_in_data.col1;
    assign x[2] = r_in_data.col2;
    assign x[3] = r_in_data.col3;

    assign start = r_in_data.first_row || (r_rows == 2'd0);
    assign diff  = {x[0][SAMPLE_W-1], x[0]} - {r_prev[SAMPLE_W-1], r_prev};
    assign down  = diff[SAMPLE_W];
    assign up    = !diff[SAMPLE_W] && (diff != '0);

    always_comb begin
        n_step    = r_step;
        n_order   = r_order;
        n_spacing = r_spacing;
        n_rows    = r_rows;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            n_ext[2*c]   = r_ext[2*c];
            n_ext[2*c+1] = r_ext[2*c+1];
        end
        if (start) begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                n_ext[2*c]   = x[c];
                n_ext[2*c+1] = x[c];
            end
            n_step    = '0;
            n_order   = ORD_NONE;
            n_spacing = 1'b1;
            n_rows    = 2'd1;
        end else begin
            if (r_rows == 2'd1) begin
                n_step  = diff;
                n_order = up ? ORD_ASC : (down ? ORD_DESC : ORD_NONE);
                n_rows  = 2'd2;
            end else begin
                if ((r_order == ORD_ASC && down) || (r_order == ORD_DESC && up)) begin
                    n_order = ORD_NONE;
                end
                if (diff != r_step) begin
                    n_spacing = 1'b0;
                end
            end
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                if (x[c] < r_ext[2*c]) begin
                    n_ext[2*c] = x[c];
                end
                if (r_ext[2*c+1] < x[c]) begin
                    n_ext[2*c+1] = x[c];
                end
            end
        end
        if (r_in_data.last_row) begin
            n_rows = 2'd0;
        end
    end

    always_comb begin
        if (r_cols == '0) begin
            used = COLS_W'(1);
        end else if (r_cols > MAX_COLS) begin
            used = MAX_COLS;
        end else begin
            used = r_cols;
        end
        for (int k = 0; k < 8; k++) begin
            shown[k] = '0;
        end
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            if (COLS_W'(c) < used) begin
                shown[2*c]   = n_ext[2*c];
                shown[2*c+1] = n_ext[2*c+1];
            end
        end
        n_result.min0           = shown[0];
        n_result.max0           = shown[1];
        n_result.min1           = shown[2];
        n_result.max1           = shown[3];
        n_result.min2           = shown[4];
        n_result.max2           = shown[5];
        n_result.min3           = shown[6];
        n_result.max3           = shown[7];
        n_result.ordering       = n_order;
        n_result.equally_spaced = n_spacing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= COLS_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rows      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_cols <= i_cfg_wdata;
            end
            if (i_row.ready) begin
                r_in_valid <= i_row.valid;
            end
            if (advance) begin
                r_out_valid <= proc && r_in_data.last_row;
            end
            if (proc) begin
                r_rows <= n_rows;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_row.valid && i_row.ready) begin
            r_in_data <= i_row.data;
        end
        if (proc) begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                r_ext[2*c]   <= n_ext[2*c];
                r_ext[2*c+1] <= n_ext[2*c+1];
            end
            r_prev    <= x[0];
            r_step    <= n_step;
            r_order   <= n_order;
            r_spacing <= n_spacing;
            if (r_in_data.last_row) begin
                r_out_data <= n_result;
            end
        end
    end

`ifndef SYNTHESIS
    a_rows_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows != 2'd3)
        else $error("Row count reached an unused value.");

    a_last_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_data.last_row) |=> (r_out_valid && r_rows == 2'd0))
        else $error("A last row did not produce a result.");

    a_start_clears_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && start) |=> (r_order == ORD_NONE && r_spacing && r_rows != 2'd2))
        else $error("A new dataset did not clear the flags.");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.min0 <= r_out_data.max0))
        else $error("Abscissa minimum exceeds maximum.");
`endif

endmodule
`default_nettype wire
